/* rtl/core/ir_pulse_frame_matcher_top_assert.svh */
// Assertion macros used by the frame matcher top module.
// Each macro expects a clock named clk and a reset named rst in the using scope.
`ifndef IR_PULSE_FRAME_MATCHER_TOP_ASSERT_SVH
`define IR_PULSE_FRAME_MATCHER_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define IFM_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define IFM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/ifm_pkg.sv */
// Package for the IR pulse frame matcher: widths, register indexes,
// reset values and the configuration struct. No dependencies.
package ifm_pkg;

  localparam int TICK_W      = 7;
  localparam int TICK_MAX    = 127;
  localparam int WANT_W      = TICK_W + 1;
  localparam int TOL_W       = 3;
  localparam int CODE_W      = 32;
  localparam int CODE_IDX_W  = $clog2(CODE_W);
  localparam int CFG_IDX_W   = 4;
  localparam int CFG_DATA_W  = 32;

  localparam int MAX_RUNS_DEF  = 128;
  localparam int CODE_BITS_DEF = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_EXPECTED_CODE      = 4'd0,
    REG_MATCH_TOLERANCE    = 4'd1,
    REG_END_GAP_THRESHOLD  = 4'd2,
    REG_LEADER_MARK_TICKS  = 4'd3,
    REG_LEADER_SPACE_TICKS = 4'd4,
    REG_BIT_MARK_TICKS     = 4'd5,
    REG_ZERO_SPACE_TICKS   = 4'd6,
    REG_ONE_SPACE_TICKS    = 4'd7
  } ifm_reg_t;

  typedef struct packed {
    logic [CODE_W-1:0] expected_code;
    logic [TOL_W-1:0]  match_tolerance;
    logic [TICK_W-1:0] end_gap_threshold;
    logic [TICK_W-1:0] leader_mark_ticks;
    logic [TICK_W-1:0] leader_space_ticks;
    logic [TICK_W-1:0] bit_mark_ticks;
    logic [TICK_W-1:0] zero_space_ticks;
    logic [TICK_W-1:0] one_space_ticks;
  } ifm_cfg_t;

  localparam ifm_cfg_t CFG_RESET = '{
    expected_code:      32'hB946_FF00,
    match_tolerance:    3'd1,
    end_gap_threshold:  7'd32,
    leader_mark_ticks:  7'd32,
    leader_space_ticks: 7'd16,
    bit_mark_ticks:     7'd2,
    zero_space_ticks:   7'd2,
    one_space_ticks:    7'd6
  };

endpackage

/* rtl/core/ifm_run_check.sv */
// Compares one closed run against the expected run for its position.
// Depends on ifm_pkg for widths and the configuration struct.
module ifm_run_check #(
  parameter int MAX_RUNS  = ifm_pkg::MAX_RUNS_DEF,
  parameter int CODE_BITS = ifm_pkg::CODE_BITS_DEF
) (
  input  logic [$clog2(MAX_RUNS)-1:0] run_number,
  input  logic [ifm_pkg::TICK_W-1:0]  run_ticks,
  input  ifm_pkg::ifm_cfg_t           cfg,
  output logic                        run_bad
);
  import ifm_pkg::*;

  localparam int RW           = $clog2(MAX_RUNS);
  localparam int LAST_BIT_RUN = 2 + 2 * CODE_BITS;
  localparam logic [RW-1:0] RUN_LEADER_MARK  = RW'(1);
  localparam logic [RW-1:0] RUN_LEADER_SPACE = RW'(2);
  localparam logic [RW-1:0] RUN_FIRST_MARK   = RW'(3);
  localparam logic [RW-1:0] RUN_FIRST_SPACE  = RW'(4);
  localparam logic [RW-1:0] RUN_LAST_SPACE   = RW'(LAST_BIT_RUN);
  localparam logic [RW-1:0] RUN_STOP_MARK    = RW'(LAST_BIT_RUN + 1);
  localparam logic [RW-1:0] RUN_END_GAP      = RW'(LAST_BIT_RUN + 2);

  logic [RW-1:0]         bit_pos;
  logic [CODE_IDX_W-1:0] bit_idx;
  logic                  known;
  logic [WANT_W-1:0]     want;
  logic [WANT_W-1:0]     ticks_ext;
  logic [WANT_W-1:0]     diff;

  assign bit_pos   = (run_number >> 1) - RW'(2);
  assign bit_idx   = bit_pos[CODE_IDX_W-1:0];
  assign ticks_ext = {1'b0, run_ticks};

  always_comb begin
    known = 1'b1;
    want  = '0;
    if (run_number == RUN_LEADER_MARK) begin
      want = {1'b0, cfg.leader_mark_ticks};
    end else if (run_number == RUN_LEADER_SPACE) begin
      want = {1'b0, cfg.leader_space_ticks};
    end else if (run_number >= RUN_FIRST_MARK && run_number <= RUN_STOP_MARK &&
                 run_number[0]) begin
      want = {1'b0, cfg.bit_mark_ticks};
    end else if (run_number >= RUN_FIRST_SPACE && run_number <= RUN_LAST_SPACE &&
                 !run_number[0]) begin
      want = cfg.expected_code[bit_idx] ? {1'b0, cfg.one_space_ticks}
                                        : {1'b0, cfg.zero_space_ticks};
    end else if (run_number == RUN_END_GAP) begin
      want = {1'b0, cfg.end_gap_threshold} + WANT_W'(1);
    end else begin
      known = 1'b0;
    end
  end

  assign diff    = (ticks_ext > want) ? (ticks_ext - want) : (want - ticks_ext);
  assign run_bad = !known || (diff > {{(WANT_W-TOL_W){1'b0}}, cfg.match_tolerance});

endmodule

/* rtl/core/ir_pulse_frame_matcher_top.sv */
// IR pulse frame matcher: takes one receiver pin sample per transfer and
// reports one result per finished frame. Depends on ifm_pkg, ifm_run_check and ir_pulse_frame_matcher_top_assert.svh.
//
// The block takes one pin sample in every clock cycle unless the input is stalled.
// Each sample updates the run state in the same cycle, and the result of a frame
// that ends on that sample is registered into the output register, or into the
// second result register while the output side stalls; that register lets samples
// keep flowing, and only when both result registers are full is the input stalled.
// Configuration writes are always taken.
module ir_pulse_frame_matcher_top #(
  parameter int MAX_RUNS  = ifm_pkg::MAX_RUNS_DEF,
  parameter int CODE_BITS = ifm_pkg::CODE_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             pin_level,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             frame_matched,
  output logic                             led_level,
  output logic [ifm_pkg::TICK_W-1:0]       runs_seen,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [ifm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ifm_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import ifm_pkg::*;

  `include "ir_pulse_frame_matcher_top_assert.svh"

  localparam int RW = $clog2(MAX_RUNS);
  localparam logic [RW-1:0] RUN_MAX    = RW'(MAX_RUNS - 1);
  localparam logic [RW-1:0] RUN_FRAME  = RW'(4 + 2 * CODE_BITS);
  localparam logic [RW-1:0] RUN_REPORT = RW'(TICK_MAX);
  localparam logic [TICK_W-1:0] TICKS_FULL = TICK_W'(TICK_MAX);

  ifm_cfg_t cfg;

  logic              in_frame, in_frame_next;
  logic              run_level, run_level_next;
  logic [TICK_W-1:0] run_ticks, run_ticks_next;
  logic [RW-1:0]     run_number, run_number_next;
  logic              mismatch_seen, mismatch_seen_next;
  logic              led_out, led_out_next;

  logic              in_take;
  logic              closed_bad;
  logic              gap_bad;
  logic              lvl1;
  logic [TICK_W-1:0] ticks1;
  logic [RW-1:0]     num1;
  logic              mm1;
  logic              mm2;
  logic              frame_end;
  logic              res_valid;
  logic              res_matched;
  logic [TICK_W-1:0] res_runs;

  logic              skid_valid;
  logic              skid_matched;
  logic              skid_led;
  logic [TICK_W-1:0] skid_runs;
  logic              out_take;

  assign cfg_ready = 1'b1;
  assign in_stall  = skid_valid;
  assign in_take   = in_valid && !in_stall;
  assign out_take  = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_EXPECTED_CODE:      cfg.expected_code      <= cfg_data[CODE_W-1:0];
        REG_MATCH_TOLERANCE:    cfg.match_tolerance    <= cfg_data[TOL_W-1:0];
        REG_END_GAP_THRESHOLD:  cfg.end_gap_threshold  <= cfg_data[TICK_W-1:0];
        REG_LEADER_MARK_TICKS:  cfg.leader_mark_ticks  <= cfg_data[TICK_W-1:0];
        REG_LEADER_SPACE_TICKS: cfg.leader_space_ticks <= cfg_data[TICK_W-1:0];
        REG_BIT_MARK_TICKS:     cfg.bit_mark_ticks     <= cfg_data[TICK_W-1:0];
        REG_ZERO_SPACE_TICKS:   cfg.zero_space_ticks   <= cfg_data[TICK_W-1:0];
        REG_ONE_SPACE_TICKS:    cfg.one_space_ticks    <= cfg_data[TICK_W-1:0];
        default: begin
        end
      endcase
    end
  end

  ifm_run_check #(.MAX_RUNS(MAX_RUNS), .CODE_BITS(CODE_BITS)) u_check_closed (
    .run_number (run_number),
    .run_ticks  (run_ticks),
    .cfg        (cfg),
    .run_bad    (closed_bad)
  );

  ifm_run_check #(.MAX_RUNS(MAX_RUNS), .CODE_BITS(CODE_BITS)) u_check_gap (
    .run_number (num1),
    .run_ticks  (ticks1),
    .cfg        (cfg),
    .run_bad    (gap_bad)
  );

  always_comb begin
    lvl1   = run_level;
    ticks1 = run_ticks;
    num1   = run_number;
    mm1    = mismatch_seen;
    if (!in_frame) begin
      if (!pin_level) begin
        lvl1   = 1'b0;
        ticks1 = TICK_W'(1);
        num1   = RW'(1);
        mm1    = 1'b0;
      end
    end else if (pin_level == run_level) begin
      if (run_ticks < TICKS_FULL) begin
        ticks1 = run_ticks + TICK_W'(1);
      end
    end else begin
      lvl1   = pin_level;
      ticks1 = TICK_W'(1);
      mm1    = mismatch_seen || closed_bad;
      if (run_number >= RUN_MAX - RW'(1)) begin
        num1 = RUN_MAX;
        mm1  = 1'b1;
      end else begin
        num1 = run_number + RW'(1);
      end
    end
  end

  assign frame_end   = in_frame && pin_level &&
                       (ticks1 > cfg.end_gap_threshold || ticks1 == TICKS_FULL);
  assign mm2         = mm1 || gap_bad;
  assign res_matched = !mm2 && (num1 == RUN_FRAME);
  assign res_runs    = (num1 > RUN_REPORT) ? TICKS_FULL : num1[TICK_W-1:0];
  assign res_valid   = in_take && frame_end;

  always_comb begin
    in_frame_next      = in_frame;
    run_level_next     = run_level;
    run_ticks_next     = run_ticks;
    run_number_next    = run_number;
    mismatch_seen_next = mismatch_seen;
    led_out_next       = led_out;
    if (in_take) begin
      if (frame_end) begin
        in_frame_next      = 1'b0;
        run_level_next     = 1'b1;
        run_ticks_next     = '0;
        run_number_next    = '0;
        mismatch_seen_next = 1'b0;
        led_out_next       = led_out ^ res_matched;
      end else begin
        in_frame_next      = in_frame || !pin_level;
        run_level_next     = lvl1;
        run_ticks_next     = ticks1;
        run_number_next    = num1;
        mismatch_seen_next = mm1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame      <= 1'b0;
      run_level     <= 1'b1;
      run_ticks     <= '0;
      run_number    <= '0;
      mismatch_seen <= 1'b0;
      led_out       <= 1'b0;
    end else begin
      in_frame      <= in_frame_next;
      run_level     <= run_level_next;
      run_ticks     <= run_ticks_next;
      run_number    <= run_number_next;
      mismatch_seen <= mismatch_seen_next;
      led_out       <= led_out_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_take) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end
    end else if (res_valid) begin
      if (!out_valid || out_take) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (out_take) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_take) begin
        frame_matched <= skid_matched;
        led_level     <= skid_led;
        runs_seen     <= skid_runs;
      end
    end else if (res_valid) begin
      if (!out_valid || out_take) begin
        frame_matched <= res_matched;
        led_level     <= led_out_next;
        runs_seen     <= res_runs;
      end else begin
        skid_matched <= res_matched;
        skid_led     <= led_out_next;
        skid_runs    <= res_runs;
      end
    end
  end

  `IFM_ASSERT_SAME(a_skid_behind_out, skid_valid, out_valid, "second result held without output")
  `IFM_ASSERT_SAME(a_idle_cleared, !in_frame, run_number == '0 && run_ticks == '0, "idle state not cleared")
  `IFM_ASSERT_SAME(a_run_open, in_frame, run_ticks != '0 && run_number != '0, "open frame with empty run")
  `IFM_ASSERT_SAME(a_run_cap, in_frame && run_number == RUN_MAX, mismatch_seen, "run cap without mismatch")
  `IFM_ASSERT_SAME(a_match_count, out_valid && frame_matched, runs_seen == RUN_FRAME[TICK_W-1:0], "match with wrong run count")
  `IFM_ASSERT_NEXT(a_led_toggle, res_valid && res_matched, led_out != $past(led_out), "matched frame did not toggle LED")

endmodule
